[rtl/frame_sequence_link_monitor_assert.svh]
// assertion macros for the frame sequence link monitor
// expects clk and rst in the scope of each use
`ifndef FRAME_SEQUENCE_LINK_MONITOR_ASSERT_SVH
`define FRAME_SEQUENCE_LINK_MONITOR_ASSERT_SVH

// same-cycle implication
`define FSLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fslm_pkg.sv]
// shared types and constants of the frame sequence link monitor
// no dependencies
package fslm_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int EXT_WIDTH_DEF    = 48;
  localparam int SEQ_W            = 32;
  localparam int CFG_SB_W         = 6;
  localparam int CFG_WS_W         = 7;
  localparam int RUN_W            = 8;
  localparam int APB_AW           = 4;
  localparam int APB_DW           = 32;

  localparam logic [RUN_W-1:0]    RUN_LIMIT    = 8'd10;
  localparam logic [RUN_W-1:0]    RUN_MAX      = 8'd255;
  localparam logic [CFG_SB_W-1:0] SEQ_BITS_MAX = 6'd32;
  localparam logic [CFG_SB_W-1:0] SEQ_BITS_RST = 6'd32;
  localparam logic [CFG_WS_W-1:0] WIN_SIZE_RST = 7'd64;

  typedef enum logic [1:0] {
    REG_SEQ_BITS    = 2'd0,
    REG_WINDOW_SIZE = 2'd1,
    REG_EXT_STATS   = 2'd2,
    REG_DEV_INIT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LS_READY       = 2'd0,
    LS_ERROR       = 2'd1,
    LS_OFFLINE     = 2'd2,
    LS_NOT_STARTED = 2'd3
  } link_status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic         connected;
    link_status_t status;
    logic         lost_error;
  } link_state_t;

endpackage

[rtl/fslm_item_if.sv]
// input and result channels of the frame sequence link monitor
// depends on fslm_pkg
interface fslm_item_if import fslm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [SEQ_W-1:0] sequence_req;

  modport source (output valid, cmd, sequence_req, input ready);
  modport sink (input valid, cmd, sequence_req, output ready);
endinterface

interface fslm_result_if import fslm_pkg::*; #(
  parameter int EXT_WIDTH = EXT_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [EXT_WIDTH-1:0] total_frames;
  logic [EXT_WIDTH-1:0] lost_frames;
  logic                 link_connected;
  logic [1:0]           link_status;
  logic                 link_lost_error;

  modport source (output valid, total_frames, lost_frames, link_connected, link_status,
                  link_lost_error, input ready);
  modport sink (input valid, total_frames, lost_frames, link_connected, link_status,
                link_lost_error, output ready);
endinterface

[rtl/fslm_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module fslm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fslm_alu.sv]
// shared add/subtract unit of the extended-sequence datapath
// depends on fslm_pkg
module fslm_alu import fslm_pkg::*; #(
  parameter int W = EXT_WIDTH_DEF
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] res,
  output logic         co
);

  logic [W:0] wide;

  always_comb begin
    case (op)
      ALU_ADD: wide = {1'b0, a} + {1'b0, b};
      ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      default: wide = '0;
    endcase
  end

  // carry on add, borrow on subtract
  assign res = wide[W-1:0];
  assign co  = wide[W];

endmodule

[rtl/fslm_link.sv]
// period run counters and connect/disconnect state of the link
// depends on fslm_pkg
module fslm_link import fslm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic        had_frame,
  input  logic        dev_init,
  output link_state_t state
);

  logic [RUN_W-1:0] run_with;
  logic [RUN_W-1:0] run_without;
  logic [RUN_W-1:0] run_with_next;
  logic [RUN_W-1:0] run_without_next;
  link_state_t      state_next;

  always_comb begin
    state_next = state;
    if (had_frame) begin
      run_with_next    = (run_with < RUN_MAX) ? run_with + 1'b1 : run_with;
      run_without_next = '0;
    end else begin
      run_with_next    = '0;
      run_without_next = (run_without < RUN_MAX) ? run_without + 1'b1 : run_without;
    end
    if (run_with_next >= RUN_LIMIT && !state.connected) begin
      state_next.connected  = 1'b1;
      state_next.lost_error = 1'b0;
      if (dev_init) begin
        state_next.status = LS_READY;
      end
    end
    if (run_without_next >= RUN_LIMIT && state_next.connected) begin
      state_next.connected  = 1'b0;
      state_next.lost_error = 1'b1;
      state_next.status     = LS_OFFLINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_with    <= '0;
      run_without <= '0;
      state       <= '{connected: 1'b0, status: LS_NOT_STARTED, lost_error: 1'b0};
    end else if (tick) begin
      run_with    <= run_with_next;
      run_without <= run_without_next;
      state       <= state_next;
    end
  end

endmodule

[rtl/frame_sequence_link_monitor.sv]
// Frame sequence link monitor. Frame items (cmd 0) are checked against a window of recently
// seen sequence numbers held in a single-port-read ram; a duplicate is dropped, a new number
// is stored (unless the window size is zero) and unwrapped into an extended sequence with one
// shared add/subtract unit. Tick items (cmd 1) advance the connect logic and give one result
// with the frame totals and link state. One item is in work at a time: a frame walks the window
// through the ram read port, and a duplicate or the first frame ends sooner; a tick passes
// through the shared adder (skipped with external statistics set) and may wait for the result
// register. Configuration sits on an APB port, register i at byte address 4*i.
`include "frame_sequence_link_monitor_assert.svh"

module frame_sequence_link_monitor import fslm_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int EXT_WIDTH    = EXT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  fslm_item_if.sink         item_ch,
  fslm_result_if.source     result_ch
);

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_WS_W) ? CNT_W : CFG_WS_W;
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SEARCH = 11'b000_0000_0010,
    ST_EVICT  = 11'b000_0000_0100,
    ST_WRITE  = 11'b000_0000_1000,
    ST_COUNT  = 11'b000_0001_0000,
    ST_DELTA  = 11'b000_0010_0000,
    ST_STEP   = 11'b000_0100_0000,
    ST_DIFF   = 11'b000_1000_0000,
    ST_TOTAL  = 11'b001_0000_0000,
    ST_LOST   = 11'b010_0000_0000,
    ST_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [CFG_SB_W-1:0] seq_bits;
  logic [CFG_WS_W-1:0] window_size;
  logic                external_stats;
  logic                device_initialized;
  logic                cfg_wr;

  // window
  logic [CNT_W-1:0] seen_fill;
  logic [PTR_W-1:0] seen_oldest;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] issue_cnt;
  logic             cmp_pending;
  logic [SEQ_W-1:0] ram_rdata;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] evict_cnt;
  logic [SUM_W-1:0] ev_sum;
  logic [SUM_W-1:0] wr_sum;
  logic [PTR_W-1:0] oldest_ev;

  // extended sequence and totals
  logic [SEQ_W-1:0]     seq_q;
  logic [EXT_WIDTH-1:0] first_ext;
  logic [EXT_WIDTH-1:0] last_ext;
  logic                 have_first;
  logic [EXT_WIDTH-1:0] unique_rx;
  logic                 period_had_frame;
  logic [EXT_WIDTH-1:0] shown_total;
  logic [EXT_WIDTH-1:0] shown_lost;
  logic [EXT_WIDTH-1:0] diff_q;
  logic [EXT_WIDTH-1:0] total_q;
  logic [SEQ_W-1:0]     step_q;
  logic [CFG_SB_W-1:0]  bits_eff;
  logic [SEQ_W-1:0]     seq_mask;
  logic [SEQ_W-1:0]     seq_half;
  logic [SEQ_W-1:0]     seq_delta;
  logic [SEQ_W-1:0]     step_next;

  // shared unit
  alu_op_t              alu_op;
  logic [EXT_WIDTH-1:0] alu_a;
  logic [EXT_WIDTH-1:0] alu_b;
  logic [EXT_WIDTH-1:0] alu_res;
  logic                 alu_co;

  logic        accept;
  logic        tick;
  link_state_t link;
  logic        res_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits           <= SEQ_BITS_RST;
      window_size        <= WIN_SIZE_RST;
      external_stats     <= 1'b0;
      device_initialized <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SEQ_BITS:    seq_bits           <= pwdata[CFG_SB_W-1:0];
        REG_WINDOW_SIZE: window_size        <= pwdata[CFG_WS_W-1:0];
        REG_EXT_STATS:   external_stats     <= pwdata[0];
        REG_DEV_INIT:    device_initialized <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SEQ_BITS:    prdata = APB_DW'(seq_bits);
      REG_WINDOW_SIZE: prdata = APB_DW'(window_size);
      REG_EXT_STATS:   prdata = APB_DW'(external_stats);
      REG_DEV_INIT:    prdata = APB_DW'(device_initialized);
      default:         prdata = '0;
    endcase
  end

  assign item_ch.ready = (state == ST_IDLE);
  assign accept        = item_ch.valid && item_ch.ready;
  assign tick          = accept && item_ch.cmd;

  fslm_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (seq_q),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  fslm_alu #(
    .W (EXT_WIDTH)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .co  (alu_co)
  );

  fslm_link u_link (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .had_frame (period_had_frame),
    .dev_init  (device_initialized),
    .state     (link)
  );

  // window limit, eviction and write address
  always_comb begin
    if (CMP_W'(window_size) >= CMP_W'(WINDOW_DEPTH)) begin
      lim = CNT_W'(WINDOW_DEPTH);
    end else begin
      lim = CNT_W'(window_size);
    end
    evict_cnt = seen_fill - lim + 1'b1;
    ev_sum    = SUM_W'(seen_oldest) + SUM_W'(evict_cnt);
    if (ev_sum >= SUM_W'(WINDOW_DEPTH)) begin
      ev_sum = ev_sum - SUM_W'(WINDOW_DEPTH);
    end
    oldest_ev = ev_sum[PTR_W-1:0];
    wr_sum    = SUM_W'(seen_oldest) + SUM_W'(seen_fill);
    if (wr_sum >= SUM_W'(WINDOW_DEPTH)) begin
      wr_sum = wr_sum - SUM_W'(WINDOW_DEPTH);
    end
    ram_waddr = wr_sum[PTR_W-1:0];
    ram_we    = (state == ST_WRITE);
  end

  // unwrap step modulo 2^bits
  always_comb begin
    if (seq_bits == '0 || seq_bits > SEQ_BITS_MAX) begin
      bits_eff = SEQ_BITS_MAX;
    end else begin
      bits_eff = seq_bits;
    end
    if (bits_eff == SEQ_BITS_MAX) begin
      seq_mask = '1;
    end else begin
      seq_mask = (SEQ_W'(1) << bits_eff) - SEQ_W'(1);
    end
    seq_half  = SEQ_W'(1) << (bits_eff - 1'b1);
    seq_delta = (seq_q - last_ext[SEQ_W-1:0]) & seq_mask;
    if (seq_delta == '0) begin
      step_next = '0;
    end else if (seq_delta <= seq_half) begin
      step_next = seq_delta;
    end else begin
      step_next = SEQ_W'(1);
    end
  end

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = last_ext;
    alu_b  = EXT_WIDTH'(step_q);
    case (state)
      ST_COUNT: begin
        alu_a = unique_rx;
        alu_b = EXT_WIDTH'(1);
      end
      ST_DIFF: begin
        alu_op = ALU_SUB;
        alu_b  = first_ext;
      end
      ST_TOTAL: begin
        alu_a = diff_q;
        alu_b = EXT_WIDTH'(1);
      end
      ST_LOST: begin
        alu_op = ALU_SUB;
        alu_a  = total_q;
        alu_b  = unique_rx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      seen_fill        <= '0;
      seen_oldest      <= '0;
      cmp_pending      <= 1'b0;
      first_ext        <= '0;
      last_ext         <= '0;
      have_first       <= 1'b0;
      unique_rx        <= '0;
      period_had_frame <= 1'b0;
      shown_total      <= '0;
      shown_lost       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            seq_q       <= item_ch.sequence_req;
            rd_ptr      <= seen_oldest;
            issue_cnt   <= '0;
            cmp_pending <= 1'b0;
            if (item_ch.cmd) begin
              period_had_frame <= 1'b0;
              state            <= external_stats ? ST_EMIT : ST_DIFF;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (cmp_pending && ram_rdata == seq_q) begin
            cmp_pending <= 1'b0;
            state       <= ST_IDLE;
          end else if (issue_cnt < seen_fill) begin
            rd_ptr      <= (rd_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
            issue_cnt   <= issue_cnt + 1'b1;
            cmp_pending <= 1'b1;
          end else begin
            cmp_pending <= 1'b0;
            state       <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          if (lim == '0) begin
            seen_fill   <= '0;
            seen_oldest <= '0;
            state       <= ST_COUNT;
          end else begin
            if (seen_fill >= lim) begin
              seen_oldest <= oldest_ev;
              seen_fill   <= lim - 1'b1;
            end
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          seen_fill <= seen_fill + 1'b1;
          state     <= ST_COUNT;
        end
        ST_COUNT: begin
          unique_rx        <= alu_co ? '1 : alu_res;
          period_had_frame <= 1'b1;
          if (!have_first) begin
            have_first <= 1'b1;
            first_ext  <= EXT_WIDTH'(seq_q);
            last_ext   <= EXT_WIDTH'(seq_q);
            state      <= ST_IDLE;
          end else begin
            state <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          step_q <= step_next;
          state  <= ST_STEP;
        end
        ST_STEP: begin
          last_ext <= alu_co ? '1 : alu_res;
          state    <= ST_IDLE;
        end
        ST_DIFF: begin
          diff_q <= alu_res;
          state  <= ST_TOTAL;
        end
        ST_TOTAL: begin
          if (!have_first) begin
            total_q <= '0;
          end else begin
            total_q <= alu_co ? '1 : alu_res;
          end
          state <= ST_LOST;
        end
        ST_LOST: begin
          shown_total <= total_q;
          shown_lost  <= alu_co ? '0 : alu_res;
          state       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  assign res_load = (state == ST_EMIT) && (!result_ch.valid || result_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_ch.valid <= 1'b0;
    end else if (res_load) begin
      result_ch.valid <= 1'b1;
    end else if (result_ch.ready) begin
      result_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result_ch.total_frames    <= shown_total;
      result_ch.lost_frames     <= shown_lost;
      result_ch.link_connected  <= link.connected;
      result_ch.link_status     <= link.status;
      result_ch.link_lost_error <= link.lost_error;
    end
  end

  `FSLM_ASSERT_NEXT(a_busy_after_accept, accept, !item_ch.ready, "ready while an item is in work")
  `FSLM_ASSERT_NOW(a_fill_bound, 1'b1, seen_fill <= CNT_W'(WINDOW_DEPTH), "window fill overrun")
  `FSLM_ASSERT_NOW(a_lost_not_conn, link.lost_error, !link.connected, "lost error while connected")
  `FSLM_ASSERT_NOW(a_ext_order, have_first, last_ext >= first_ext, "last sequence behind first")

endmodule
